// ===== rtl/nfa_pkg.sv =====
// Shared constants, types and a helper function for the NFA acceptance checker.
`timescale 1ns / 1ps

package nfa_pkg;

    // Automaton size
    localparam int NUM_STATES  = 8;
    localparam int NUM_SYMBOLS = 4;

    // Fixed field widths of the register map and the item payloads
    localparam int MAX_STATES  = 8;
    localparam int MAX_SYMBOLS = 4;
    localparam int CHAR_W      = 8;
    localparam int SET_W       = 8;
    localparam int IDX_W       = 3;
    localparam int SIZE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bits of a set that name real states
    localparam logic [SET_W-1:0] STATE_MASK = SET_W'((1 << NUM_STATES) - 1);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEXT_SETS0,
        REG_NEXT_SETS1,
        REG_NEXT_SETS2,
        REG_NEXT_SETS3,
        REG_ALPHABET_CHARS,
        REG_ALPHABET_SIZE,
        REG_START_INDEX,
        REG_FINAL_INDEX
    } cfg_reg_t;

    // Configuration state
    typedef struct packed {
        logic [MAX_SYMBOLS-1:0][MAX_STATES-1:0][SET_W-1:0] next_sets;
        logic [MAX_SYMBOLS-1:0][CHAR_W-1:0]                alphabet_chars;
        logic [SIZE_W-1:0]                                 alphabet_size;
        logic [IDX_W-1:0]                                  start_index;
        logic [IDX_W-1:0]                                  final_index;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [NUM_SYMBOLS-1:0] match;
        logic                   is_first;
        logic                   no_symbol;
    } q_entry_t;

    // One-hot set for a state index; out-of-range index gives the empty set
    function automatic logic [SET_W-1:0] one_hot(input logic [IDX_W-1:0] idx);
        logic [SET_W-1:0] res;
        res = '0;
        if (int'(idx) < NUM_STATES)
        begin
            res = SET_W'(1) << idx;
        end
        return res;
    endfunction

endpackage

// ===== rtl/nfa_in_if.sv =====
// Input channel: one character beat per handshake.
`timescale 1ns / 1ps

interface nfa_in_if;
    logic                       valid;
    logic                       ready;
    logic [nfa_pkg::CHAR_W-1:0] char_in;
    logic                       is_first;
    logic                       no_symbol;

    modport source (output valid, output char_in, output is_first, output no_symbol,
                    input ready);
    modport sink   (input valid, input char_in, input is_first, input no_symbol,
                    output ready);
endinterface

// ===== rtl/nfa_out_if.sv =====
// Output channel: one result beat per input beat.
`timescale 1ns / 1ps

interface nfa_out_if;
    logic                      valid;
    logic                      ready;
    logic [nfa_pkg::SET_W-1:0] active_set;
    logic                      accepted;
    logic                      dead;

    modport source (output valid, output active_set, output accepted, output dead,
                    input ready);
    modport sink   (input valid, input active_set, input accepted, input dead,
                    output ready);
endinterface

// ===== rtl/nfa_front.sv =====
// Front end: accepts input beats and matches the character against the alphabet.
`timescale 1ns / 1ps

module nfa_front (
    input  nfa_pkg::cfg_t     cfg,
    nfa_in_if.sink            in_ch,
    output logic              push_valid,
    input  logic              push_ready,
    output nfa_pkg::q_entry_t push_entry
);
    import nfa_pkg::*;

    // Handshake goes straight through to the queue
    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

    // Per-entry match: entry in use and character equal
    always_comb
    begin
        for (int j = 0; j < NUM_SYMBOLS; j++)
        begin
            push_entry.match[j] = (j < int'(cfg.alphabet_size)) &&
                                  (cfg.alphabet_chars[j] == in_ch.char_in);
        end
        push_entry.is_first  = in_ch.is_first;
        push_entry.no_symbol = in_ch.no_symbol;
    end

endmodule

// ===== rtl/nfa_queue.sv =====
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module nfa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  nfa_pkg::q_entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output nfa_pkg::q_entry_t pop_entry
);
    import nfa_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill-count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/nfa_back.sv =====
// Back end: advances the active state set and holds the result register.
`timescale 1ns / 1ps

module nfa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  nfa_pkg::cfg_t     cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  nfa_pkg::q_entry_t pop_entry,
    nfa_out_if.source         out_ch
);
    import nfa_pkg::*;

    logic [SET_W-1:0] set_reg, set_next;
    logic             valid_reg, valid_next;
    logic [SET_W-1:0] active_set_reg;
    logic             accepted_reg;
    logic             dead_reg;
    logic [SET_W-1:0] seed;
    logic [SET_W-1:0] step_set;
    logic             pop;

    // Take a new item when the result slot is free or being drained
    assign pop_ready = !valid_reg || out_ch.ready;
    assign pop       = pop_valid && pop_ready;

    // Seed, then OR the masks of every active state under every matching entry; with no symbol the seed passes through
    always_comb
    begin
        seed     = pop_entry.is_first ? one_hot(cfg.start_index) : (set_reg & STATE_MASK);
        step_set = '0;
        for (int j = 0; j < NUM_SYMBOLS; j++)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                if (pop_entry.match[j] && seed[s])
                begin
                    step_set = step_set | cfg.next_sets[j][s];
                end
            end
        end
        set_next = pop_entry.no_symbol ? seed : (step_set & STATE_MASK);
    end

    // Result slot occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                set_reg <= set_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            active_set_reg <= set_next;
            accepted_reg   <= (set_next & one_hot(cfg.final_index)) != '0;
            dead_reg       <= (set_next == '0);
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.active_set = active_set_reg;
    assign out_ch.accepted   = accepted_reg;
    assign out_ch.dead       = dead_reg;

endmodule

// ===== rtl/nfa_acceptance_checker.sv =====
// Each beat passes the queue, then the result register. Throughput: one item
// per cycle unless the output stalls; the set update is a combinational OR of
// the back end's transition masks, fed by a 2-entry queue from the front end.
// Reset (rst_n low, async): active set empty, queue and result slot empty,
// registers at defaults (alphabet size 1, all others zero).
`timescale 1ns / 1ps

module nfa_acceptance_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data,
    nfa_in_if.sink                         in_ch,
    nfa_out_if.source                      out_ch
);
    import nfa_pkg::*;

    cfg_t     cfg_reg;
    logic     push_valid, push_ready;
    q_entry_t push_entry;
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{next_sets:      '0,
                         alphabet_chars: '0,
                         alphabet_size:  SIZE_W'(1),
                         start_index:    '0,
                         final_index:    '0};
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_NEXT_SETS0:     cfg_reg.next_sets[0]   <= cfg_data;
                REG_NEXT_SETS1:     cfg_reg.next_sets[1]   <= cfg_data;
                REG_NEXT_SETS2:     cfg_reg.next_sets[2]   <= cfg_data;
                REG_NEXT_SETS3:     cfg_reg.next_sets[3]   <= cfg_data;
                REG_ALPHABET_CHARS: cfg_reg.alphabet_chars <= cfg_data[31:0];
                REG_ALPHABET_SIZE:  cfg_reg.alphabet_size  <= cfg_data[SIZE_W-1:0];
                REG_START_INDEX:    cfg_reg.start_index    <= cfg_data[IDX_W-1:0];
                REG_FINAL_INDEX:    cfg_reg.final_index    <= cfg_data[IDX_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    nfa_front u_front (
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    nfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    nfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_ch    (out_ch)
    );

`ifndef SYNTH
    // An accepted input beat is queued for the back end on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> pop_valid)
        else $error("accepted beat missing from queue");

    // Seeding with no character yields exactly the start state
    a_seed_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready && pop_entry.is_first && pop_entry.no_symbol
        |=> out_ch.active_set == one_hot(cfg_reg.start_index))
        else $error("empty-string seed mismatch");

    // Acceptance agrees with the final state and the dead flag
    a_accept_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.accepted
        |-> !out_ch.dead && ((out_ch.active_set & one_hot(cfg_reg.final_index)) != '0))
        else $error("accepted flag inconsistent with set");
`endif

endmodule
